### rtl/memory_operand_instruction_executor_top_macros.svh
// Assertion macros used by the executor back end (moie_back).
`ifndef MEMORY_OPERAND_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define MEMORY_OPERAND_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define MOIE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MOIE_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define MOIE_ASSERT(label, clk, rst, prop, msg)

`define MOIE_NEVER(label, clk, rst, expr, msg)

`endif

`endif

### rtl/moie_pkg.sv
package moie_pkg;

   localparam int MEM_WORDS   = 1024;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int PROG_WORDS  = 4096;
   localparam int PC_W        = 12;
   localparam int WORD_W      = 32;
   localparam int DEST_W      = 10;
   localparam int OP_W        = 4;
   localparam int JUMP_BACK   = 2;
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_AW      = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 4'd0,
      OP_NEG    = 4'd1,
      OP_MUL    = 4'd2,
      OP_JMP    = 4'd3,
      OP_JMP0   = 4'd4,
      OP_ASSIGN = 4'd5,
      OP_LE     = 4'd6,
      OP_READ   = 4'd7,
      OP_WRITE  = 4'd8,
      OP_HALT   = 4'd9
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] a_value;
      logic                     a_is_addr;
      logic signed [WORD_W-1:0] b_value;
      logic                     b_is_addr;
      logic [DEST_W-1:0]        dest_addr;
      logic [PC_W-1:0]          jump_target;
      logic [PC_W-1:0]          pc;
      logic signed [WORD_W-1:0] read_value;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]          next_pc;
      logic signed [WORD_W-1:0] result_value;
      logic                     dest_written;
      logic                     shown;
      logic                     halted;
      logic                     error;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   a_value;
      logic                a_use_mem;
      logic [WORD_W-1:0]   b_value;
      logic                b_use_mem;
      logic [MEM_AW-1:0]   dest;
      logic                writes;
      logic                bad;
      logic [WORD_W-1:0]   read_value;
      logic [PC_W-1:0]     pc;
      logic [PC_W-1:0]     next_seq;
      logic [PC_W-1:0]     next_jump;
   } cmd_type;

endpackage

### rtl/memory_operand_instruction_executor_top.sv
// channel   ports                   transaction taken at
// request   push, full, req_data    push high, full low
// response  empty, pop, rsp_data    pop high, empty low
//
// Sustains one instruction per cycle unless clearing or the response queue backs up.
// Rate is set by the two-read, one-write data memory with forwarding of the last write.
// Synchronous reset starts a clear of all 1024 words; full stays high until it ends.
// Holding pop low fills the 4-entry response queue, then the 2-entry command queue.
module memory_operand_instruction_executor_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  moie_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output moie_pkg::rsp_type rsp_data
);
   import moie_pkg::*;

   logic                  clearing;
   logic                  cmd_valid, cmd_ready;
   cmd_type               cmd;
   logic [RSP_CNT_W-1:0]  rsp_count;
   logic                  rsp_wr_en;
   rsp_type               rsp_wr_data;

   moie_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .clearing  (clearing),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   moie_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .clearing    (clearing),
      .rsp_count   (rsp_count),
      .rsp_wr_en   (rsp_wr_en),
      .rsp_wr_data (rsp_wr_data)
   );

   moie_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_wr_en),
      .wr_data  (rsp_wr_data),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data),
      .count    (rsp_count)
   );

endmodule

### rtl/moie_front.sv
module moie_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  moie_pkg::req_type req_data,
   input  logic              clearing,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output moie_pkg::cmd_type cmd
);
   import moie_pkg::*;

   cmd_type                 queue_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   cmd_type                 classified;
   logic                    push_ok, pop_ok;
   logic                    known, uses_a, uses_b, writes, jump;
   logic                    bad_a, bad_b, bad_dest, bad_tgt;

   always_comb begin
      known  = 1'b1;
      uses_a = 1'b0;
      uses_b = 1'b0;
      writes = 1'b0;
      jump   = 1'b0;
      unique case (req_data.op)
         OP_ADD, OP_MUL, OP_LE: begin
            uses_a = 1'b1;
            uses_b = 1'b1;
            writes = 1'b1;
         end
         OP_NEG, OP_ASSIGN: begin
            uses_a = 1'b1;
            writes = 1'b1;
         end
         OP_WRITE: begin
            uses_a = 1'b1;
         end
         OP_JMP0: begin
            uses_a = 1'b1;
            jump   = 1'b1;
         end
         OP_READ: begin
            writes = 1'b1;
         end
         OP_JMP: begin
            jump = 1'b1;
         end
         OP_HALT: begin
            known = 1'b1;
         end
         default: begin
            known = 1'b0;
         end
      endcase

      bad_a    = uses_a && req_data.a_is_addr &&
                 ($unsigned(req_data.a_value) >= WORD_W'(MEM_WORDS));
      bad_b    = uses_b && req_data.b_is_addr &&
                 ($unsigned(req_data.b_value) >= WORD_W'(MEM_WORDS));
      bad_dest = writes && (WORD_W'(req_data.dest_addr) >= WORD_W'(MEM_WORDS));
      bad_tgt  = jump && (req_data.jump_target < PC_W'(JUMP_BACK));

      classified.op         = op_type'(req_data.op);
      classified.a_value    = req_data.a_value;
      classified.a_use_mem  = uses_a && req_data.a_is_addr;
      classified.b_value    = req_data.b_value;
      classified.b_use_mem  = uses_b && req_data.b_is_addr;
      classified.dest       = MEM_AW'(req_data.dest_addr);
      classified.writes     = writes;
      classified.bad        = !known || bad_a || bad_b || bad_dest || bad_tgt;
      classified.read_value = req_data.read_value;
      classified.pc         = req_data.pc;
      classified.next_seq   = PC_W'(({1'b0, req_data.pc} + (PC_W+1)'(1)) % PROG_WORDS);
      classified.next_jump  = PC_W'(({1'b0, req_data.jump_target} -
                                     (PC_W+1)'(JUMP_BACK)) % PROG_WORDS);
   end

   assign full      = clearing || (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push_ok   = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign pop_ok    = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? CMDQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? CMDQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CMDQ_CNT_W'(count_ff + CMDQ_CNT_W'(push_ok) - CMDQ_CNT_W'(pop_ok));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### rtl/moie_rsp_fifo.sv
module moie_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  moie_pkg::rsp_type             wr_data,
   input  logic                          pop,
   output logic                          empty,
   output moie_pkg::rsp_type             rsp_data,
   output logic [moie_pkg::RSP_CNT_W-1:0] count
);
   import moie_pkg::*;

   rsp_type                entries_ff [RSP_DEPTH];
   logic [RSP_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [RSP_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   rd_en;

   assign empty    = (count_ff == '0);
   assign rd_en    = pop && !empty;
   assign rsp_data = entries_ff[rd_ptr_ff];
   assign count    = count_ff;

   always_comb begin
      wr_ptr_in = wr_en ? RSP_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? RSP_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = RSP_CNT_W'(count_ff + RSP_CNT_W'(wr_en) - RSP_CNT_W'(rd_en));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/moie_back.sv
`include "memory_operand_instruction_executor_top_macros.svh"

module moie_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  moie_pkg::cmd_type              cmd,
   output logic                           clearing,
   input  logic [moie_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic                           rsp_wr_en,
   output moie_pkg::rsp_type              rsp_wr_data
);
   import moie_pkg::*;

   logic [WORD_W-1:0]  mem_ff [MEM_WORDS];
   logic               clr_active_ff, clr_active_in;
   logic [MEM_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic               ex_valid_ff, ex_valid_in;
   cmd_type            ex_ff;
   logic [WORD_W-1:0]  rd_a_ff, rd_b_ff;
   logic               wb_valid_ff, wb_valid_in;
   logic [MEM_AW-1:0]  wb_addr_ff;
   logic [WORD_W-1:0]  wb_data_ff;
   logic               issue, room;
   logic [WORD_W-1:0]  a_op, b_op, res;
   logic [MEM_AW-1:0]  a_addr, b_addr;
   logic               ex_write, mem_we;
   logic [MEM_AW-1:0]  mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   rsp_type            rsp;

   assign clearing  = clr_active_ff;
   assign room      = (RSP_CNT_W'(rsp_count + RSP_CNT_W'(ex_valid_ff))) <
                      RSP_CNT_W'(RSP_DEPTH);
   assign issue     = cmd_valid && !clr_active_ff && room;
   assign cmd_ready = issue;

   assign a_addr = ex_ff.a_value[MEM_AW-1:0];
   assign b_addr = ex_ff.b_value[MEM_AW-1:0];

   always_comb begin
      if (!ex_ff.a_use_mem) begin
         a_op = ex_ff.a_value;
      end else if (wb_valid_ff && (wb_addr_ff == a_addr)) begin
         a_op = wb_data_ff;
      end else begin
         a_op = rd_a_ff;
      end
      if (!ex_ff.b_use_mem) begin
         b_op = ex_ff.b_value;
      end else if (wb_valid_ff && (wb_addr_ff == b_addr)) begin
         b_op = wb_data_ff;
      end else begin
         b_op = rd_b_ff;
      end
   end

   always_comb begin
      rsp.next_pc      = ex_ff.next_seq;
      rsp.dest_written = 1'b0;
      rsp.shown        = 1'b0;
      rsp.halted       = 1'b0;
      rsp.error        = ex_ff.bad;
      res              = '0;
      if (!ex_ff.bad) begin
         unique case (ex_ff.op)
            OP_ADD:    res = WORD_W'(a_op + b_op);
            OP_NEG:    res = WORD_W'('0 - a_op);
            OP_MUL:    res = WORD_W'(a_op * b_op);
            OP_ASSIGN: res = a_op;
            OP_LE:     res = WORD_W'($signed(a_op) <= $signed(b_op));
            OP_READ:   res = ex_ff.read_value;
            OP_WRITE: begin
               res       = a_op;
               rsp.shown = 1'b1;
            end
            OP_JMP: begin
               rsp.next_pc = ex_ff.next_jump;
            end
            OP_JMP0: begin
               if (a_op == '0) begin
                  rsp.next_pc = ex_ff.next_jump;
               end
            end
            OP_HALT: begin
               rsp.halted  = 1'b1;
               rsp.next_pc = ex_ff.pc;
            end
            default: begin
               res = '0;
            end
         endcase
         rsp.dest_written = ex_ff.writes;
      end
      rsp.result_value = res;
   end

   assign ex_write    = ex_valid_ff && ex_ff.writes && !ex_ff.bad;
   assign rsp_wr_en   = ex_valid_ff;
   assign rsp_wr_data = rsp;

   assign mem_we    = clr_active_ff || ex_write;
   assign mem_waddr = clr_active_ff ? clr_addr_ff : ex_ff.dest;
   assign mem_wdata = clr_active_ff ? '0 : res;

   always_comb begin
      clr_active_in = clr_active_ff && (clr_addr_ff != MEM_AW'(MEM_WORDS - 1));
      clr_addr_in   = clr_active_ff ? MEM_AW'(clr_addr_ff + 1'b1) : clr_addr_ff;
      ex_valid_in   = issue;
      wb_valid_in   = ex_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         ex_valid_ff   <= 1'b0;
         wb_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         ex_valid_ff   <= ex_valid_in;
         wb_valid_ff   <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         ex_ff   <= cmd;
         rd_a_ff <= mem_ff[cmd.a_value[MEM_AW-1:0]];
         rd_b_ff <= mem_ff[cmd.b_value[MEM_AW-1:0]];
      end
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      wb_addr_ff <= ex_ff.dest;
      wb_data_ff <= res;
   end

   `MOIE_ASSERT(a_clear_covers_all, clock, reset, $fell(clr_active_ff) |-> ($past(clr_addr_ff) == MEM_AW'(MEM_WORDS - 1)), "clear pass ended early")
   `MOIE_ASSERT(a_exec_follows_issue, clock, reset, ex_valid_ff |-> $past(issue), "exec stage without issue")
   `MOIE_NEVER(a_rsp_no_overflow, clock, reset, ex_valid_ff && (rsp_count >= RSP_CNT_W'(RSP_DEPTH)), "response queue overflow")
   `MOIE_NEVER(a_no_exec_in_clear, clock, reset, clr_active_ff && ex_valid_ff, "instruction executed during clear pass")

endmodule

### tb/moie_result_checker.sv
`timescale 1ns / 100ps

module moie_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  moie_pkg::req_type req_data,
   input  logic              empty,
   input  logic              pop,
   input  moie_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding,
   output int                checked,
   output int                flagged
);
   import moie_pkg::*;

   logic [WORD_W-1:0] mem_image [MEM_WORDS];
   rsp_type           pending_results [$];

   function automatic logic [WORD_W-1:0] load_operand(input logic [WORD_W-1:0] value,
                                                      input logic is_addr,
                                                      inout logic bad);
      if (!is_addr) begin
         return value;
      end
      if (value >= MEM_WORDS) begin
         bad = 1'b1;
         return '0;
      end
      return mem_image[value[MEM_AW-1:0]];
   endfunction

   function automatic rsp_type execute_instruction(input req_type ins);
      rsp_type           res;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              bad;
      logic              writes;
      res = '0;
      res.next_pc = ins.pc + 1'b1;
      a = '0;
      b = '0;
      bad = 1'b0;
      writes = 1'b0;
      case (ins.op)
         OP_ADD, OP_MUL, OP_LE: begin
            a = load_operand(ins.a_value, ins.a_is_addr, bad);
            b = load_operand(ins.b_value, ins.b_is_addr, bad);
            writes = 1'b1;
         end
         OP_NEG, OP_ASSIGN, OP_WRITE, OP_JMP0: begin
            a = load_operand(ins.a_value, ins.a_is_addr, bad);
            writes = (ins.op == OP_NEG) || (ins.op == OP_ASSIGN);
         end
         OP_READ: begin
            writes = 1'b1;
         end
         OP_JMP, OP_HALT: begin
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      if (writes && (ins.dest_addr >= MEM_WORDS)) begin
         bad = 1'b1;
      end
      if (((ins.op == OP_JMP) || (ins.op == OP_JMP0)) && (ins.jump_target < JUMP_BACK)) begin
         bad = 1'b1;
      end
      if (bad) begin
         res.error = 1'b1;
         return res;
      end
      case (ins.op)
         OP_ADD:    res.result_value = a + b;
         OP_NEG:    res.result_value = '0 - a;
         OP_MUL:    res.result_value = a * b;
         OP_ASSIGN: res.result_value = a;
         OP_LE:     res.result_value = ($signed(a) <= $signed(b)) ? 1 : 0;
         OP_READ:   res.result_value = ins.read_value;
         OP_WRITE: begin
            res.result_value = a;
            res.shown = 1'b1;
         end
         OP_JMP:    res.next_pc = ins.jump_target - PC_W'(JUMP_BACK);
         OP_JMP0: begin
            if (a == '0) begin
               res.next_pc = ins.jump_target - PC_W'(JUMP_BACK);
            end
         end
         default: begin
            res.halted = 1'b1;
            res.next_pc = ins.pc;
         end
      endcase
      if (writes) begin
         mem_image[ins.dest_addr] = res.result_value;
         res.dest_written = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (mem_image[i]) mem_image[i] = '0;
         pending_results.delete();
         mismatches = 0;
         checked = 0;
         flagged = 0;
      end else begin
         if (pop && !empty) begin
            checked++;
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result next_pc=%h value=%h wr=%b shown=%b halt=%b err=%b",
                        $time, rsp_data.next_pc, rsp_data.result_value, rsp_data.dest_written,
                        rsp_data.shown, rsp_data.halted, rsp_data.error);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  $display("%0t: expected next_pc=%h value=%h wr=%b shown=%b halt=%b err=%b",
                           $time, want.next_pc, want.result_value, want.dest_written,
                           want.shown, want.halted, want.error);
                  $display("%0t:   actual next_pc=%h value=%h wr=%b shown=%b halt=%b err=%b",
                           $time, rsp_data.next_pc, rsp_data.result_value,
                           rsp_data.dest_written, rsp_data.shown, rsp_data.halted,
                           rsp_data.error);
               end
            end
         end
         if (push && !full) begin
            want = execute_instruction(req_data);
            if (want.error) begin
               flagged++;
            end
            pending_results.insert(pending_results.size(), want);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

### tb/tb_memory_operand_instruction_executor_top.sv
`timescale 1ns / 100ps

module tb_memory_operand_instruction_executor_top;
   import moie_pkg::*;

   localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 4'd10;
   localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 4'd15;
   localparam int ITEMS_PER_PHASE = 267;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   int      mismatches;
   int      outstanding;
   int      checked;
   int      flagged;
   int      sent_count = 0;
   int      tx_idle_pct = 0;
   int      rx_idle_pct = 0;
   logic    rx_hold = 1'b0;
   logic    hold_done = 1'b0;
   int      quiet_cycles = 0;

   memory_operand_instruction_executor_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   moie_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .flagged     (flagged)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL memory_operand_instruction_executor_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (rx_hold && !hold_done) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic req_type instr(input logic [OP_W-1:0] op,
                                     input logic [WORD_W-1:0] a, input logic a_addr,
                                     input logic [WORD_W-1:0] b, input logic b_addr,
                                     input logic [DEST_W-1:0] dest,
                                     input logic [PC_W-1:0] target, input logic [PC_W-1:0] pc,
                                     input logic [WORD_W-1:0] rd);
      req_type ins;
      ins.op = op;
      ins.a_value = a;
      ins.a_is_addr = a_addr;
      ins.b_value = b;
      ins.b_is_addr = b_addr;
      ins.dest_addr = dest;
      ins.jump_target = target;
      ins.pc = pc;
      ins.read_value = rd;
      return ins;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(5))
         0: return '0;
         1: return $urandom_range(7);
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0000;
         4: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_address();
      case ($urandom_range(9))
         0: return $urandom();
         1: return MEM_WORDS + $urandom_range(3);
         2, 3, 4: return $urandom_range(MEM_WORDS - 1);
         default: return $urandom_range(15);
      endcase
   endfunction

   function automatic req_type random_instruction();
      req_type ins;
      if ($urandom_range(99) < 8) begin
         ins.op = OP_W'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
      end else begin
         ins.op = OP_W'($urandom_range(OP_HALT, OP_ADD));
      end
      ins.a_is_addr = 1'($urandom_range(1));
      ins.a_value = ins.a_is_addr ? random_address() : random_word();
      ins.b_is_addr = 1'($urandom_range(1));
      ins.b_value = ins.b_is_addr ? random_address() : random_word();
      ins.dest_addr = ($urandom_range(99) < 70) ? DEST_W'($urandom_range(15)) :
                      DEST_W'($urandom_range(MEM_WORDS - 1));
      ins.jump_target = ($urandom_range(99) < 5) ? PC_W'($urandom_range(1)) :
                        PC_W'($urandom());
      ins.pc = ($urandom_range(99) < 5) ? PC_W'(PROG_WORDS - 1) : PC_W'($urandom());
      ins.read_value = random_word();
      return ins;
   endfunction

   task automatic send_instruction(input req_type ins);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push <= 1'b1;
      req_data <= ins;
      @(posedge clock);
      while (full) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      push <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_instruction(instr(OP_READ, 0, 0, 0, 0, 1023, 0, 0, 32'h8000_0000));
      send_instruction(instr(OP_READ, 0, 0, 0, 0, 0, 0, 1, 32'h7fff_ffff));
      send_instruction(instr(OP_ADD, 1023, 1, 0, 1, 1, 0, 2, 0));
      send_instruction(instr(OP_ADD, 32'h7fff_ffff, 0, 1, 0, 2, 0, 3, 0));
      send_instruction(instr(OP_NEG, 32'h8000_0000, 0, 0, 0, 3, 0, 4, 0));
      send_instruction(instr(OP_MUL, 0, 1, 0, 1, 4, 0, 5, 0));
      send_instruction(instr(OP_MUL, 32'hffff_ffff, 0, 32'h8000_0000, 0, 5, 0, 6, 0));
      send_instruction(instr(OP_LE, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 6, 0, 7, 0));
      send_instruction(instr(OP_LE, 0, 1, 1023, 1, 7, 0, 8, 0));
      send_instruction(instr(OP_LE, 1, 1, 32'hffff_ffff, 0, 8, 0, 9, 0));
      send_instruction(instr(OP_ASSIGN, 1, 1, 0, 0, 9, 0, 10, 0));
      send_instruction(instr(OP_WRITE, 1023, 1, 0, 0, 0, 0, 11, 0));
      send_instruction(instr(OP_WRITE, 32'hffff_ffff, 0, 0, 0, 0, 0, 12, 0));
      send_instruction(instr(OP_JMP, 0, 0, 0, 0, 0, 4095, 13, 0));
      send_instruction(instr(OP_JMP, 0, 0, 0, 0, 0, 2, 14, 0));
      send_instruction(instr(OP_JMP, 0, 0, 0, 0, 0, 1, 15, 0));
      send_instruction(instr(OP_JMP0, 0, 0, 0, 0, 0, 100, 16, 0));
      send_instruction(instr(OP_JMP0, 1, 1, 0, 0, 0, 100, 17, 0));
      send_instruction(instr(OP_JMP0, 5, 0, 0, 0, 0, 0, 18, 0));
      send_instruction(instr(OP_HALT, 0, 0, 0, 0, 0, 0, 4095, 0));
      send_instruction(instr(OP_ADD, 1, 0, 2, 0, 10, 0, 4095, 0));
      send_instruction(instr(OP_UNKNOWN_LO, 0, 0, 0, 0, 11, 0, 19, 0));
      send_instruction(instr(OP_UNKNOWN_HI, 0, 0, 0, 0, 12, 0, 20, 0));
      send_instruction(instr(OP_ADD, 1024, 1, 0, 0, 13, 0, 21, 0));
      send_instruction(instr(OP_NEG, 32'hffff_ffff, 1, 0, 0, 14, 0, 22, 0));
      send_instruction(instr(OP_MUL, 3, 0, 32'h8000_0000, 1, 15, 0, 23, 0));
      wait_for_results();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 78 : 0;
         rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 25 : 0;
         if (phase == 2) begin
            rx_hold = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) send_instruction(random_instruction());
         wait_for_results();
      end

      $display("Summary: %0d instructions issued, %0d results compared, %0d expected faults",
               sent_count, checked, flagged);
      $display("Summary: corner cases, three stall mixes and a long response back-pressure");
      if (mismatches == 0) begin
         $display("PASS memory_operand_instruction_executor_top");
      end else begin
         $display("FAIL memory_operand_instruction_executor_top");
      end
      $finish;
   end

endmodule
